/* hw/rtl/csvp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csvp_pkg
// Shared types and constants for the CSV signed integer parser.
// ----------------------------------------------------------------------------
package csvp_pkg;

    // Width of a parsed field value, two's complement, wrapping.
    localparam int VALUE_WIDTH = 32;

    // Packed result payload: index, value, count, padded to whole bytes.
    localparam int PAYLOAD_W = 8 + VALUE_WIDTH + 8;
    localparam int TDATA_W   = ((PAYLOAD_W + 7) / 8) * 8;

    // Field limit after reset.
    localparam logic [7:0] LIMIT_RESET = 8'd8;

    // Characters the parser recognizes.
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // The frame is stopped once a field holds more than this many digits.
    localparam logic [3:0] MAX_DIGITS = 4'd10;

    // Result kinds.
    typedef enum logic {
        KIND_FIELD = 1'b0,
        KIND_DONE  = 1'b1
    } kind_t;

    // One result item.
    typedef struct packed {
        kind_t                   kind;
        logic [7:0]              index;
        logic [VALUE_WIDTH-1:0]  value;
        logic [7:0]              count;
        logic                    last;
    } result_t;

    // Results caused by one byte, as handed from the parser to the queue.
    typedef struct packed {
        logic    valid0;
        logic    valid1;
        result_t res0;
        result_t res1;
    } step_out_t;

endpackage : csvp_pkg
`default_nettype wire

/* hw/rtl/csvp_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csvp_parser
// Parse state and per-byte decode. Computes the results of one byte and
// updates the field accumulator, sign, digit count, index and drain flag.
// ----------------------------------------------------------------------------
module csvp_parser
    import csvp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        step,
    input  wire logic [7:0]  char_byte,
    input  wire logic        frame_end,
    output step_out_t        step_out
);

    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic                   neg_reg, neg_next;
    logic [3:0]             digits_reg, digits_next;
    logic [7:0]             index_reg, index_next;
    logic                   drain_reg, drain_next;
    logic [7:0]             limit_reg;

    logic [7:0]             index_inc;
    logic [VALUE_WIDTH-1:0] signed_acc;
    logic [VALUE_WIDTH-1:0] acc_times_ten;
    logic [7:0]             digit_full;
    logic [3:0]             digit;
    logic                   is_digit;
    logic                   stop;
    logic [7:0]             stop_count;
    logic                   done_now;

    // Shared arithmetic for the decode below.
    assign index_inc     = index_reg + 8'd1;
    assign signed_acc    = neg_reg ? (VALUE_WIDTH'(0) - acc_reg) : acc_reg;
    assign acc_times_ten = (acc_reg << 3) + (acc_reg << 1);
    assign digit_full    = char_byte - CHAR_ZERO;
    assign digit         = digit_full[3:0];
    assign is_digit      = (char_byte >= CHAR_ZERO) && (char_byte <= CHAR_NINE);

    // Decode one byte into results and the next parse state.
    always_comb begin
        result_t r0;
        result_t r1;
        r0          = '{kind: KIND_DONE, index: 8'd0, value: '0, count: 8'd0, last: 1'b1};
        r1          = r0;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        digits_next = digits_reg;
        index_next  = index_reg;
        drain_next  = drain_reg;
        step_out.valid0 = 1'b0;
        step_out.valid1 = 1'b0;
        stop        = 1'b0;
        stop_count  = index_reg;
        done_now    = 1'b0;

        if (drain_reg) begin
            // Bytes after done are dropped; the frame end clears everything.
            if (frame_end) begin
                acc_next    = '0;
                neg_next    = 1'b0;
                digits_next = 4'd0;
                index_next  = 8'd0;
                drain_next  = 1'b0;
            end
        end else if (index_reg >= limit_reg) begin
            step_out.valid0 = 1'b1;
            r0.count        = index_reg;
            done_now        = 1'b1;
        end else if (char_byte == CHAR_COMMA) begin
            // Emit the field, then close the frame at the limit or frame end.
            step_out.valid0 = 1'b1;
            r0.kind         = KIND_FIELD;
            r0.index        = index_reg;
            r0.value        = signed_acc;
            acc_next        = '0;
            neg_next        = 1'b0;
            digits_next     = 4'd0;
            index_next      = index_inc;
            if ((index_inc >= limit_reg) || frame_end) begin
                r0.last         = 1'b0;
                step_out.valid1 = 1'b1;
                r1.count        = index_inc;
                done_now        = 1'b1;
            end
        end else begin
            priority if ((digits_reg == 4'd0) && (char_byte == CHAR_MINUS) && !neg_reg) begin
                neg_next = 1'b1;
            end else if (digits_reg > MAX_DIGITS) begin
                stop = 1'b1;
            end else if ((char_byte == CHAR_SPACE) || (char_byte == CHAR_DOT)) begin
                // Skipped character.
            end else if (!is_digit) begin
                if ((digits_reg == 4'd0) && (index_reg != 8'd0)) begin
                    stop_count = index_reg - 8'd1;
                end
                stop = 1'b1;
            end else begin
                acc_next    = acc_times_ten + VALUE_WIDTH'(digit);
                digits_next = digits_reg + 4'd1;
            end
            if (stop || frame_end) begin
                step_out.valid0 = 1'b1;
                r0.count        = stop_count;
                done_now        = 1'b1;
            end
        end

        // A done result closes the frame: drain, or clear at the frame end.
        if (done_now) begin
            acc_next    = '0;
            neg_next    = 1'b0;
            digits_next = 4'd0;
            if (frame_end) begin
                index_next = 8'd0;
                drain_next = 1'b0;
            end else begin
                drain_next = 1'b1;
            end
        end

        step_out.res0 = r0;
        step_out.res1 = r1;
    end

    // Parse state advances on each accepted transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg    <= '0;
            neg_reg    <= 1'b0;
            digits_reg <= 4'd0;
            index_reg  <= 8'd0;
            drain_reg  <= 1'b0;
        end else if (step) begin
            acc_reg    <= acc_next;
            neg_reg    <= neg_next;
            digits_reg <= digits_next;
            index_reg  <= index_next;
            drain_reg  <= drain_next;
        end
    end

    // Field limit register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

endmodule : csvp_parser
`default_nettype wire

/* hw/rtl/csvp_out_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// csvp_out_fifo
// Four-entry result queue. Takes up to two results per cycle and hands out
// one per cycle while out_ready is high; reports room for two more as space_ok.
// ----------------------------------------------------------------------------
module csvp_out_fifo
    import csvp_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  step_out_t   push_data,
    output logic        space_ok,
    output logic        out_valid,
    input  wire logic   out_ready,
    output result_t     out_data
);

    result_t    slot_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       push0;
    logic       push1;
    logic       pop;
    logic [1:0] wr_ptr_plus1;

    assign push0        = push && push_data.valid0;
    assign push1        = push && push_data.valid1;
    assign pop          = out_valid && out_ready;
    assign wr_ptr_plus1 = wr_ptr_reg + 2'd1;

    assign out_valid = (count_reg != 3'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign space_ok  = (count_reg <= 3'd2);

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg + {1'b0, push0} + {1'b0, push1};
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {2'b00, push0} + {2'b00, push1} - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage, written in transfer order.
    always_ff @(posedge aclk) begin
        if (push0) begin
            slot_reg[wr_ptr_reg] <= push_data.res0;
        end
        if (push1) begin
            slot_reg[wr_ptr_plus1] <= push_data.res1;
        end
    end

endmodule : csvp_out_fifo
`default_nettype wire

/* hw/rtl/csv_signed_integer_parser_top.sv */
`default_nettype none
// Each result is written into the result queue and leaves it on the m_ side in order.
// Throughput: one byte per cycle while s_tready is high; a comma that also
// closes the frame makes two results, which leave one per cycle through a
// four-entry result queue while m_tready is high. s_tready drops while fewer
// than two queue entries are free. Reset (aresetn low, synchronous) clears
// the parse state, empties the queue and sets field_limit to 8.
// ----------------------------------------------------------------------------
// csv_signed_integer_parser_top
// Parses comma-terminated signed decimal integers from a framed byte stream
// and reports each field and a done result with the field count.
// ----------------------------------------------------------------------------
module csv_signed_integer_parser_top
    import csvp_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // Field limit register write.
    input  wire logic               cfg_wr_en,
    input  wire logic [7:0]         cfg_wr_data,
    // Byte input.
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,   // [7:0] char_byte
    input  wire logic               s_tlast,   // frame_end
    // Result output.
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // [7:0] field_index, [VALUE_WIDTH+7:8] field_value,
    // [VALUE_WIDTH+15:VALUE_WIDTH+8] field_count, rest zero
    output logic [TDATA_W-1:0]      m_tdata,
    output logic                    m_tuser,   // kind
    output logic                    m_tlast    // last_of_run
);

    logic      step;
    logic      space_ok;
    step_out_t step_out;
    result_t   head;

    // A byte transfer happens when s_tvalid is high and the queue can take two results.
    assign s_tready = space_ok;
    assign step     = s_tvalid && s_tready;

    csvp_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (step),
        .char_byte   (s_tdata),
        .frame_end   (s_tlast),
        .step_out    (step_out)
    );

    csvp_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (step),
        .push_data (step_out),
        .space_ok  (space_ok),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head)
    );

    // Pack the queue head onto the stream.
    assign m_tdata = TDATA_W'({head.count, head.value, head.index});
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule : csv_signed_integer_parser_top
`default_nettype wire
